FILE: src/byte_sorter_ascending_defines.svh
// Assertion macros shared by the sorter RTL.
`ifndef BYTE_SORTER_ASCENDING_DEFINES_SVH
`define BYTE_SORTER_ASCENDING_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define BSA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorter assertion failed");
// Next-cycle implication.
`define BSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorter assertion failed");
// Condition that must never hold.
`define BSA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("sorter assertion failed");
`else
`define BSA_ASSERT_NOW(lbl, ante, cons)
`define BSA_ASSERT_NEXT(lbl, ante, cons)
`define BSA_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: src/bsa_pkg.sv
`default_nettype none

package bsa_pkg;

  // Number of cells in the chain.
  localparam int DEPTH = 32;
  // Fill count width, able to hold DEPTH itself.
  localparam int CNT_W = $clog2(DEPTH + 1);

  // One request of the input channel.
  typedef struct packed {
    logic [7:0] in_value;
    logic       in_last;
  } bsa_in_t;

  // One request of the result channel.
  typedef struct packed {
    logic [7:0] sorted_value;
    logic       out_last;
    logic       overflow;
  } bsa_out_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;
    logic shl;
  } bsa_ctl_t;

  // Controller states.
  typedef enum logic {
    ST_FILL,
    ST_DRAIN
  } bsa_state_t;

endpackage

`default_nettype wire

FILE: src/bsa_cell.sv
`default_nettype none

module bsa_cell (
  input  wire logic              clk,
  input  wire bsa_pkg::bsa_ctl_t ctl,
  input  wire logic [7:0]        new_val,
  input  wire logic              occ,
  input  wire logic              left_gt,
  input  wire logic [7:0]        left_val,
  input  wire logic [7:0]        right_val,
  output logic [7:0]             val,
  output logic                   gt
);
  import bsa_pkg::*;

  logic [7:0] val_r;
  logic [7:0] val_nxt;

  // An empty cell counts as larger than any byte, so it takes part in insertion.
  assign gt  = !occ || (val_r > new_val);
  assign val = val_r;

  // Insertion: bytes above the new one move one cell up, and the first such
  // cell takes the new byte. Draining moves every byte one cell down.
  always_comb begin
    val_nxt = val_r;
    if (ctl.shl) begin
      val_nxt = right_val;
    end else if (ctl.ins && gt) begin
      val_nxt = left_gt ? left_val : new_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

FILE: src/byte_sorter_ascending.sv
// Insertion sorter over a chain of DEPTH cells: one input byte is taken per cycle while filling.
// A byte that finds room is in place in the chain in the cycle after its request is accepted.
// After the marked byte the list drains smallest first, one result per cycle while
// out_ready is high; no input is taken while draining, so input is held off until
// the last result of the list is taken, however long the receiver holds out_ready low.
// Synchronous active-low reset empties the chain and clears the overflow flag.
`default_nettype none
`include "byte_sorter_ascending_defines.svh"

module byte_sorter_ascending (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bsa_pkg::bsa_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bsa_pkg::bsa_out_t      out_data
);
  import bsa_pkg::*;

  bsa_state_t       state_r;
  bsa_state_t       state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             dropped_r;
  logic             dropped_nxt;

  logic             in_fire;
  logic             out_fire;
  logic             room;
  logic             final_out;
  bsa_ctl_t         ctl;

  logic [7:0]       cell_val [DEPTH];
  logic             cell_gt  [DEPTH];

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign room      = count_r < CNT_W'(DEPTH);
  assign final_out = count_r == CNT_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILL: begin
        if (in_fire && in_data.in_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_fire && final_out) begin
          state_nxt = ST_FILL;
        end
      end
      default: state_nxt = ST_FILL;
    endcase
  end

  // Handshake and cell commands. Ready is high throughout filling and valid
  // throughout draining, so the other side's signal alone decides the transfer.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    ctl.ins   = 1'b0;
    ctl.shl   = 1'b0;
    unique case (state_r)
      ST_FILL: begin
        in_ready = 1'b1;
        ctl.ins  = in_valid && room;
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        ctl.shl   = out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Fill count and overflow flag.
  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.shl) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (in_fire && !room) begin
      dropped_nxt = 1'b1;
    end else if (out_fire && final_out) begin
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_FILL;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // The chain of cells; cell 0 always holds the smallest byte.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic       occ;
    logic       left_gt;
    logic [7:0] left_val;
    logic [7:0] right_val;

    assign occ = CNT_W'(i) < count_r;

    if (i == 0) begin : g_head
      assign left_gt  = 1'b0;
      assign left_val = '0;
    end else begin : g_body
      assign left_gt  = cell_gt[i-1];
      assign left_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end

    bsa_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_val   (in_data.in_value),
      .occ       (occ),
      .left_gt   (left_gt),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[i]),
      .gt        (cell_gt[i])
    );
  end

  // The result comes straight from the head cell's register.
  assign out_data.sorted_value = cell_val[0];
  assign out_data.out_last     = final_out;
  assign out_data.overflow     = dropped_r;

  `BSA_ASSERT_NEVER(a_ready_and_valid, in_ready && out_valid)
  `BSA_ASSERT_NEVER(a_count_bound, count_r > CNT_W'(DEPTH))
  `BSA_ASSERT_NEXT(a_last_starts_drain, in_fire && in_data.in_last, out_valid)
  `BSA_ASSERT_NEXT(a_final_ends_drain, out_fire && final_out, in_ready && count_r == '0)
  `BSA_ASSERT_NEVER(a_empty_drain, out_valid && count_r == '0)

endmodule

`default_nettype wire

FILE: dv/byte_sorter_ascending_tb.sv
`timescale 1ns / 1ps

module byte_sorter_ascending_tb;
  import bsa_pkg::*;

  // Cycles without any accepted request before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 2000;
  // Cycles allowed after the last expected result for stray output.
  localparam int unsigned DRAIN_SLACK = 40;
  // Stimulus size for the random part.
  localparam int unsigned RANDOM_ITEMS = 430;

  // Predicts the sorted lists and checks each result request against them.
  class sort_scoreboard;
    logic [7:0] held_q[$];
    bit         dropped;
    bsa_out_t   sorted_q[$];
    int unsigned errors;

    function new();
      dropped = 1'b0;
      errors  = 0;
    endfunction

    // An accepted input request: store or drop the byte, and on the last
    // byte of a list queue up the whole list in ascending order.
    function void note_request(bsa_in_t req);
      logic [7:0] list_q[$];
      logic [7:0] tmp;
      bsa_out_t   exp;
      int         n;
      int         j;
      if (held_q.size() < DEPTH) begin
        held_q.push_back(req.in_value);
      end else begin
        dropped = 1'b1;
      end
      if (!req.in_last) return;

      // Insertion sort of the held bytes.
      list_q = held_q;
      n = list_q.size();
      for (int i = 1; i < n; i++) begin
        tmp = list_q[i];
        j = i - 1;
        while (j >= 0 && list_q[j] > tmp) begin
          list_q[j + 1] = list_q[j];
          j--;
        end
        list_q[j + 1] = tmp;
      end

      for (int k = 0; k < n; k++) begin
        exp.sorted_value = list_q[k];
        exp.out_last     = (k == n - 1);
        exp.overflow     = dropped;
        sorted_q.push_back(exp);
      end
      held_q.delete();
      dropped = 1'b0;
    endfunction

    // An accepted result request: compare it with the oldest expectation.
    function void check_result(bsa_out_t got);
      bsa_out_t exp;
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected result: value %0d last %0b overflow %0b",
                 $time, got.sorted_value, got.out_last, got.overflow);
        errors++;
        return;
      end
      exp = sorted_q.pop_front();
      if (got.sorted_value !== exp.sorted_value || got.out_last !== exp.out_last ||
          got.overflow !== exp.overflow) begin
        $display("%0t: mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                 $time, exp.sorted_value, exp.out_last, exp.overflow,
                 got.sorted_value, got.out_last, got.overflow);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return sorted_q.size();
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  bsa_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  bsa_out_t out_data;

  // When set, neither side idles.
  bit calm = 1'b0;
  int unsigned sent_count = 0;

  sort_scoreboard board = new();

  byte_sorter_ascending u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver stalls at random unless the calm stretch is on.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 27);
  end

  // Both channels are observed at the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.note_request(in_data);
    if (rst_n && out_valid && out_ready) board.check_result(out_data);
  end

  // Give up if the block stops accepting or producing requests.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("** byte_sorter_ascending: FAILED **");
    $finish;
  end

  // Present one byte, with a random hold-off first, and wait for acceptance.
  // Called and returning at a falling edge; valid stays high between bytes
  // that follow each other without a gap.
  task automatic send_byte(input logic [7:0] value, input logic last);
    bsa_in_t req;
    req.in_value = value;
    req.in_last  = last;
    if (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (!calm && $urandom_range(99) < 27);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_count++;
  endtask

  // A list of random bytes; the flavour decides how often values repeat.
  task automatic send_list(input int unsigned len);
    int unsigned flavour;
    logic [7:0]  base;
    logic [7:0]  value;
    flavour = $urandom_range(3);
    base    = 8'($urandom_range(255));
    for (int unsigned i = 0; i < len; i++) begin
      case (flavour)
        0: value = base + 8'($urandom_range(3));
        1: value = $urandom_range(1) ? 8'hff : 8'h00;
        default: value = 8'($urandom_range(255));
      endcase
      send_byte(value, i == len - 1);
    end
  endtask

  initial begin : stimulus
    int unsigned roll;
    int unsigned len;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed lists: one-byte lists at both extremes, extremes with single-bit and
    // alternating bit patterns, one repeated value, and a list that holds 8'h03 twice.
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);
    send_byte(8'h07, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h07, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'hc8, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h00, 1'b1);

    // A list that only just overflows on its marked byte, then one that
    // exactly fills the buffer.
    send_list(DEPTH + 1);
    send_list(DEPTH);

    // Random lists, mostly short, some full and some overflowing.
    while (sent_count < RANDOM_ITEMS) begin
      calm = (sent_count >= 150 && sent_count < 230);
      roll = $urandom_range(99);
      if (roll < 60) len = $urandom_range(1, 8);
      else if (roll < 80) len = $urandom_range(9, DEPTH - 1);
      else if (roll < 90) len = DEPTH;
      else len = $urandom_range(DEPTH + 1, DEPTH + 8);
      send_list(len);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Let every expected result arrive, then watch for stray output.
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("** byte_sorter_ascending: PASSED **");
    end else begin
      $display("** byte_sorter_ascending: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/bsa_pkg.sv
src/bsa_cell.sv
src/byte_sorter_ascending.sv
dv/byte_sorter_ascending_tb.sv
